FILE: src/atpr_pkg.sv
// ----------------------------------------------------------------------------
// atpr_pkg: shared types, widths and constant tables for the tilt pipeline
// Holds the arctangent table, the whole-degree threshold table and the
// per-axis word that the front stage hands to each angle lane.
// ----------------------------------------------------------------------------
package atpr_pkg;

    localparam int IN_W       = 16;          // raw sample width
    localparam int SQ_W       = 31;          // square of a sample, up to 2^30
    localparam int SUM_W      = 32;          // sum of two squares, up to 2^31
    localparam int ROOT_W     = 32;          // square root result bits
    localparam int REM_W      = 2 * SUM_W;   // radicand and remainder
    localparam int FRAC_W     = 16;          // Q.16 placement of the numerator
    localparam int CW         = 36;          // CORDIC x/y, covers the gain
    localparam int ZW         = 64;          // angle accumulator, Q.60 radians
    localparam int MAG_W      = 7;           // whole degrees 0..127
    localparam int DEG_W      = 8;           // signed output angle
    localparam int MAX_STAGES = 32;
    localparam int DEG_ENTRIES = 2 ** MAG_W;

    // front stage + sum + flags + root bits + degree search + final fixup
    localparam int FIXED_LATENCY = 1 + 2 + ROOT_W + MAG_W + 1;

    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_DIV_180 = PI_Q60 / 180;
    localparam logic [63:0] PI_MOD_180 = PI_Q60 % 180;

    typedef logic [MAX_STAGES-1:0][ZW-1:0]  atan_tab_t;
    typedef logic [DEG_ENTRIES-1:0][ZW-1:0] deg_tab_t;

    typedef struct packed {
        logic            neg;
        logic [IN_W-1:0] mag;
        logic [SQ_W-1:0] sq;
    } axis_t;

    typedef struct packed {
        logic neg;
        logic num_zero;
        logic den_zero;
        logic sq_eq;
        logic sq_lt;
    } atpr_flags_t;

    // atan(2^-i) in Q.60: entry 0 is pi/4, the rest from the odd power
    // series with every term truncated on its own.
    function automatic atan_tab_t atan_table();
        atan_tab_t   tab;
        logic [63:0] acc;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        int          p;
        int          d;
        tab = '0;
        tab[0] = PI_Q60 >> 2;
        for (int i = 1; i < MAX_STAGES; i++) begin
            acc = '0;
            for (int k = 0; k < 31; k++) begin
                p = i * (2 * k + 1);
                if (p <= 60) begin
                    d = 2 * k + 1;
                    num = 64'd1 << (60 - p);
                    rem = '0;
                    quo = '0;
                    for (int b = 63; b >= 0; b--) begin
                        rem = {rem[62:0], num[b]};
                        if (rem >= 64'(d)) begin
                            rem = rem - 64'(d);
                            quo[b] = 1'b1;
                        end
                    end
                    if ((k & 1) == 1) begin
                        acc = acc - quo;
                    end
                    else begin
                        acc = acc + quo;
                    end
                end
            end
            tab[i] = acc;
        end
        return tab;
    endfunction

    // k * pi / 180 in Q.60, truncated; entries past 90 are all ones and never met
    function automatic deg_tab_t deg_table();
        deg_tab_t tab;
        for (int k = 0; k < DEG_ENTRIES; k++) begin
            if (k <= 90) begin
                tab[k] = 64'(k) * PI_DIV_180 + (64'(k) * PI_MOD_180) / 180;
            end
            else begin
                tab[k] = '1;
            end
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = atan_table();
    localparam deg_tab_t  DEG_THR  = deg_table();

    // sign, magnitude and square of one raw sample
    function automatic axis_t axis_of(input logic signed [IN_W-1:0] v);
        axis_t                    a;
        logic signed [2*IN_W-1:0] p;
        logic [IN_W-1:0]          u;
        p = v * v;
        u = v;
        a.neg = v[IN_W-1];
        a.mag = v[IN_W-1] ? (~u + IN_W'(1)) : u;
        a.sq  = p[SQ_W-1:0];
        return a;
    endfunction

endpackage

FILE: src/accel_tilt_pitch_roll.sv
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll: pitch and roll in whole degrees from one sample
// Squares the three axes, then runs two identical angle lanes in parallel.
// ----------------------------------------------------------------------------
// Usage: drive a signed 16-bit x/y/z sample with start high; the word is
// taken on any edge where busy is low, and busy is high only from reset
// until the first clock edge after it, so a new word may enter on every
// clock. Each word comes back with done high for one cycle and pitch and
// roll, each -90..90, truncated toward zero. The pipeline holds the square
// stage, the sum and compare stages, a 32-stage square root that retires
// one root bit per stage, the CORDIC chain of one rotation per stage, a
// 7-stage binary search over the degree thresholds and one output stage.
// Results are not held: the receiver must take them on the done cycle,
// since the pipeline never stalls.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [atpr_pkg::IN_W-1:0]   accel_x_in,
    input  logic signed [atpr_pkg::IN_W-1:0]   accel_y_in,
    input  logic signed [atpr_pkg::IN_W-1:0]   accel_z_in,
    output logic                               done,
    output logic signed [atpr_pkg::DEG_W-1:0]  pitch_deg,
    output logic signed [atpr_pkg::DEG_W-1:0]  roll_deg
);
    import atpr_pkg::*;

    localparam int LATENCY = FIXED_LATENCY + CORDIC_STAGES;

    logic               ready_reg;
    logic               ready_next;
    logic               accept;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] vld_next;

    // front stage: sign, magnitude and square of each axis
    axis_t ax_reg;
    axis_t ay_reg;
    axis_t az_reg;

    // hold off only until the first edge out of reset
    assign ready_next = 1'b1;
    assign busy       = !ready_reg;
    assign accept     = start && ready_reg;

    // advance the valid bit alongside the word, one position per cycle
    assign vld_next = {vld_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ready_reg <= 1'b0;
            vld_reg   <= '0;
        end
        else begin
            ready_reg <= ready_next;
            vld_reg   <= vld_next;
        end
    end

    // payload registers load every cycle; the valid bit says what counts
    always_ff @(posedge clk)
    begin
        ax_reg <= axis_of(accel_x_in);
        ay_reg <= axis_of(accel_y_in);
        az_reg <= axis_of(accel_z_in);
    end

    // pitch: atan(y / sqrt(x^2 + z^2))
    atpr_tilt #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_pitch (
        .clk   (clk),
        .num   (ay_reg),
        .a_sq  (ax_reg.sq),
        .b_sq  (az_reg.sq),
        .angle (pitch_deg)
    );

    // roll: atan(x / sqrt(y^2 + z^2))
    atpr_tilt #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_roll (
        .clk   (clk),
        .num   (ax_reg),
        .a_sq  (ay_reg.sq),
        .b_sq  (az_reg.sq),
        .angle (roll_deg)
    );

    // done taps the last valid bit; the word sits on the ports in that cycle
    assign done = vld_reg[LATENCY-1];

endmodule

FILE: src/atpr_tilt.sv
// ----------------------------------------------------------------------------
// atpr_tilt: one angle lane, atan(num / sqrt(a^2 + b^2)) in whole degrees
// Sum of squares, bit-per-stage square root, vectoring CORDIC, binary
// search against the degree thresholds, then the exact-compare fixups.
// ----------------------------------------------------------------------------
module atpr_tilt #(
    parameter int CORDIC_STAGES = 20
) (
    input  logic                               clk,
    input  atpr_pkg::axis_t                    num,
    input  logic [atpr_pkg::SQ_W-1:0]          a_sq,
    input  logic [atpr_pkg::SQ_W-1:0]          b_sq,
    output logic signed [atpr_pkg::DEG_W-1:0]  angle
);
    import atpr_pkg::*;

    localparam logic [MAG_W-1:0] DEG_45  = MAG_W'(45);
    localparam logic [MAG_W-1:0] DEG_44  = MAG_W'(44);
    localparam logic [MAG_W-1:0] DEG_89  = MAG_W'(89);
    localparam logic [MAG_W-1:0] DEG_90  = MAG_W'(90);

    // sum of squares
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  nsq_reg;
    logic [IN_W-1:0]   nmag_reg;
    logic              nneg_reg;

    assign sum_next = SUM_W'(a_sq) + SUM_W'(b_sq);

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        nsq_reg  <= SUM_W'(num.sq);
        nmag_reg <= num.mag;
        nneg_reg <= num.neg;
    end

    // square root pipeline, index 0 is the loaded radicand
    logic [REM_W-1:0]  sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [0:ROOT_W];
    logic [IN_W-1:0]   sq_mag_reg  [0:ROOT_W];
    atpr_flags_t       sq_flg_reg  [0:ROOT_W];
    atpr_flags_t       flg_next;

    always_comb
    begin
        flg_next.neg      = nneg_reg;
        flg_next.num_zero = (nmag_reg == '0);
        flg_next.den_zero = (sum_reg == '0);
        flg_next.sq_eq    = (nsq_reg == sum_reg);
        flg_next.sq_lt    = (nsq_reg < sum_reg);
    end

    always_ff @(posedge clk)
    begin
        sq_rem_reg[0]  <= {sum_reg, {SUM_W{1'b0}}};
        sq_root_reg[0] <= '0;
        sq_mag_reg[0]  <= nmag_reg;
        sq_flg_reg[0]  <= flg_next;
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int BIT = ROOT_W - 1 - j;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        // (R + 2^b)^2 - R^2 = R * 2^(b+1) + 2^(2b)
        always_comb
        begin
            trial = (REM_W'(sq_root_reg[j]) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
            if (sq_rem_reg[j] >= trial) begin
                rem_next  = sq_rem_reg[j] - trial;
                root_next = sq_root_reg[j] | (ROOT_W'(1) << BIT);
            end
            else begin
                rem_next  = sq_rem_reg[j];
                root_next = sq_root_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_rem_reg[j+1]  <= rem_next;
            sq_root_reg[j+1] <= root_next;
            sq_mag_reg[j+1]  <= sq_mag_reg[j];
            sq_flg_reg[j+1]  <= sq_flg_reg[j];
        end
    end

    // vectoring CORDIC on (root, |num| << 16)
    logic signed [CW-1:0] cx_reg  [0:CORDIC_STAGES-1];
    logic signed [CW-1:0] cy_reg  [0:CORDIC_STAGES-1];
    logic signed [ZW-1:0] cz_reg  [0:CORDIC_STAGES-1];
    atpr_flags_t          cf_reg  [0:CORDIC_STAGES-1];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        atpr_flags_t          f_in;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (i == 0) begin : g_load
            assign x_in = $signed({{(CW-ROOT_W){1'b0}}, sq_root_reg[ROOT_W]});
            assign y_in = $signed({{(CW-IN_W-FRAC_W){1'b0}}, sq_mag_reg[ROOT_W],
                                   {FRAC_W{1'b0}}});
            assign z_in = '0;
            assign f_in = sq_flg_reg[ROOT_W];
        end
        else begin : g_chain
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign z_in = cz_reg[i-1];
            assign f_in = cf_reg[i-1];
        end

        // rotate toward y = 0, strictly positive y rotates clockwise
        always_comb
        begin
            if (!y_in[CW-1] && (y_in != '0)) begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + $signed(ATAN_TAB[i]);
            end
            else begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - $signed(ATAN_TAB[i]);
            end
        end

        always_ff @(posedge clk)
        begin
            cx_reg[i] <= x_next;
            cy_reg[i] <= y_next;
            cz_reg[i] <= z_next;
            cf_reg[i] <= f_in;
        end
    end

    // largest whole degree whose threshold the angle reaches, one bit a stage
    logic [ZW-1:0]    dz_reg   [0:MAG_W-1];
    logic [MAG_W-1:0] dmag_reg [0:MAG_W-1];
    atpr_flags_t      df_reg   [0:MAG_W-1];

    for (genvar d = 0; d < MAG_W; d++) begin : g_deg
        localparam int BIT = MAG_W - 1 - d;
        logic [ZW-1:0]    z_in;
        logic [MAG_W-1:0] m_in;
        atpr_flags_t      f_in;
        logic [MAG_W-1:0] cand;
        logic [MAG_W-1:0] m_next;

        if (d == 0) begin : g_load
            // a negative angle counts as zero
            assign z_in = cz_reg[CORDIC_STAGES-1][ZW-1] ? '0 : cz_reg[CORDIC_STAGES-1];
            assign m_in = '0;
            assign f_in = cf_reg[CORDIC_STAGES-1];
        end
        else begin : g_chain
            assign z_in = dz_reg[d-1];
            assign m_in = dmag_reg[d-1];
            assign f_in = df_reg[d-1];
        end

        assign cand   = m_in | (MAG_W'(1) << BIT);
        assign m_next = (z_in >= DEG_THR[cand]) ? cand : m_in;

        always_ff @(posedge clk)
        begin
            dz_reg[d]   <= z_in;
            dmag_reg[d] <= m_next;
            df_reg[d]   <= f_in;
        end
    end

    // exact-compare fixups, vertical cap, sign
    logic [MAG_W-1:0]         fix_mag;
    logic signed [DEG_W-1:0]  angle_next;
    logic signed [DEG_W-1:0]  angle_reg;
    atpr_flags_t              fin;

    assign fin = df_reg[MAG_W-1];

    always_comb
    begin
        fix_mag = dmag_reg[MAG_W-1];
        if (fin.sq_eq) begin
            fix_mag = DEG_45;
        end
        else if (fin.sq_lt) begin
            if (fix_mag > DEG_44) begin
                fix_mag = DEG_44;
            end
        end
        else begin
            if (fix_mag < DEG_45) begin
                fix_mag = DEG_45;
            end
        end
        if (fix_mag > DEG_89) begin
            fix_mag = DEG_89;
        end
        if (fin.num_zero) begin
            fix_mag = '0;
        end
        else if (fin.den_zero) begin
            fix_mag = DEG_90;
        end
        angle_next = fin.neg ? -$signed({1'b0, fix_mag}) : $signed({1'b0, fix_mag});
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

FILE: src/atpr_chk.sv
// ----------------------------------------------------------------------------
// atpr_chk: port-level checks for the tilt pipeline
// Fixed latency in both directions, output range and the flat-sample case.
// ----------------------------------------------------------------------------
module atpr_chk #(
    parameter int CORDIC_STAGES = 20
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [atpr_pkg::IN_W-1:0]   accel_x_in,
    input logic signed [atpr_pkg::IN_W-1:0]   accel_y_in,
    input logic                               done,
    input logic signed [atpr_pkg::DEG_W-1:0]  pitch_deg,
    input logic signed [atpr_pkg::DEG_W-1:0]  roll_deg
);
    import atpr_pkg::*;

    localparam int LATENCY = FIXED_LATENCY + CORDIC_STAGES;

    // every accepted word comes back with done high at the pipeline's end
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not return on time");

    // no result without a matching accepted word
    a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching word");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_deg >= -8'sd90 && pitch_deg <= 8'sd90 &&
                  roll_deg >= -8'sd90 && roll_deg <= 8'sd90))
        else $error("angle out of range");

    // x and y both zero: both numerators vanish, so both angles are zero
    a_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && accel_x_in == '0 && accel_y_in == '0)
        |-> ##LATENCY (pitch_deg == '0 && roll_deg == '0))
        else $error("flat sample gave a nonzero angle");

endmodule

bind accel_tilt_pitch_roll atpr_chk #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_atpr_chk (.*);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for accel_tilt_pitch_roll
// Drives signed x/y/z samples through the start/busy handshake with random
// gaps, predicts pitch and roll with an independent fixed-point CORDIC
// model, and checks every done word against the oldest prediction in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STAGES     = 20;
    localparam int PIPE_DEPTH = 43 + STAGES;
    localparam int TABLE_LEN  = 32;
    localparam int IN_W       = atpr_pkg::IN_W;
    localparam int DEG_W      = atpr_pkg::DEG_W;
    // pi in Q.60 radians, truncated
    localparam logic [63:0] PI_RAD = 64'h3243F6A8885A308D;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic signed [IN_W-1:0]  x;
        logic signed [IN_W-1:0]  y;
        logic signed [IN_W-1:0]  z;
        logic signed [DEG_W-1:0] pitch;
        logic signed [DEG_W-1:0] roll;
    } tilt_word_t;

    // ------------------------------------------------------------------------
    // Angle predictor and in-order store of expected angle words.
    // ------------------------------------------------------------------------
    class tilt_scoreboard;
        longint     atan_rad [TABLE_LEN];
        tilt_word_t angles_due [$];
        int         errors;

        function new();
            longint          acc;
            longint unsigned term;
            int              p;
            errors = 0;
            // atan(2^-i) in Q.60; first entry is pi/4, the rest from the
            // odd power series with each term truncated on its own
            atan_rad[0] = longint'(PI_RAD >> 2);
            for (int i = 1; i < TABLE_LEN; i++)
            begin
                acc = 0;
                for (int k = 0; k < 64; k++)
                begin
                    p = i * (2 * k + 1);
                    if (p > 60)
                        break;
                    term = (64'd1 << (60 - p)) / longint'(2 * k + 1);
                    if (k % 2 == 1)
                        acc = acc - longint'(term);
                    else
                        acc = acc + longint'(term);
                end
                atan_rad[i] = acc;
            end
        endfunction

        // floor of the square root, one result bit per pass
        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned probe;
            r = 0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe = probe >> 2;
            while (probe != 0)
            begin
                if (v >= r + probe)
                begin
                    v = v - (r + probe);
                    r = (r >> 1) + probe;
                end
                else
                    r = r >> 1;
                probe = probe >> 2;
            end
            return r;
        endfunction

        // atan(num / sqrt(a^2 + b^2)) in whole degrees, truncated toward zero
        function logic signed [DEG_W-1:0] tilt_angle(longint num, longint a, longint b);
            longint unsigned         an;
            longint unsigned         ua;
            longint unsigned         ub;
            longint unsigned         s;
            longint unsigned         n2;
            longint unsigned         thr;
            longint                  cx;
            longint                  cy;
            longint                  cz;
            longint                  dx;
            longint                  dy;
            int unsigned             mag;
            logic signed [DEG_W-1:0] res;
            an = (num < 0) ? -num : num;
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            s  = ua * ua + ub * ub;
            n2 = an * an;
            if (an == 0)
                return '0;
            if (s == 0)
                return (num < 0) ? -DEG_W'(90) : DEG_W'(90);

            // vector (sqrt(s), |num|) in Q.16 down to the x axis
            cx = longint'(root_floor(s << 32));
            cy = longint'(an << 16);
            cz = 0;
            for (int i = 0; i < STAGES && i < TABLE_LEN; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy > 0)
                begin
                    cx = cx + dx;
                    cy = cy - dy;
                    cz = cz + atan_rad[i];
                end
                else
                begin
                    cx = cx - dx;
                    cy = cy + dy;
                    cz = cz - atan_rad[i];
                end
            end
            if (cz < 0)
                cz = 0;

            // largest whole degree whose threshold the angle reaches
            mag = 0;
            for (int k = 1; k <= 90; k++)
            begin
                thr = 64'(k) * (PI_RAD / 180) + (64'(k) * (PI_RAD % 180)) / 180;
                if ($unsigned(cz) >= thr)
                    mag = k;
                else
                    break;
            end

            // settle the 45 degree boundary exactly, keep off vertical
            if (n2 == s)
                mag = 45;
            else if (n2 < s)
            begin
                if (mag > 44)
                    mag = 44;
            end
            else if (mag < 45)
                mag = 45;
            if (mag > 89)
                mag = 89;

            res = DEG_W'(mag);
            if (num < 0)
                res = -res;
            return res;
        endfunction

        // note a sample taken by the block
        function void note_sample(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                                  logic signed [IN_W-1:0] z);
            tilt_word_t w;
            w.x = x;
            w.y = y;
            w.z = z;
            w.pitch = tilt_angle(y, x, z);
            w.roll  = tilt_angle(x, y, z);
            angles_due.push_back(w);
        endfunction

        // check one done word against the oldest prediction
        function void check_angles(logic signed [DEG_W-1:0] pitch,
                                   logic signed [DEG_W-1:0] roll);
            tilt_word_t w;
            if (angles_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected done word: pitch %0d roll %0d", pitch, roll);
                return;
            end
            w = angles_due.pop_front();
            if (pitch !== w.pitch || roll !== w.roll)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"mismatch x=%0d y=%0d z=%0d: ",
                              "pitch exp %0d got %0d, roll exp %0d got %0d"},
                             w.x, w.y, w.z, w.pitch, pitch, w.roll, roll);
            end
        endfunction

        function int pending();
            return angles_due.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [IN_W-1:0]   accel_x_in;
    logic signed [IN_W-1:0]   accel_y_in;
    logic signed [IN_W-1:0]   accel_z_in;
    logic                     done;
    logic signed [DEG_W-1:0]  pitch_deg;
    logic signed [DEG_W-1:0]  roll_deg;

    tilt_scoreboard sb;

    accel_tilt_pitch_roll #(
        .CORDIC_STAGES(STAGES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .accel_x_in(accel_x_in),
        .accel_y_in(accel_y_in),
        .accel_z_in(accel_z_in),
        .done      (done),
        .pitch_deg (pitch_deg),
        .roll_deg  (roll_deg)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sample both sides on the rising edge: a word enters when start is high
    // and busy low, a result leaves on any edge that closes a done cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_sample(accel_x_in, accel_y_in, accel_z_in);
            if (done)
                sb.check_angles(pitch_deg, roll_deg);
        end
    end

    // Hold a sample on the inputs until the block takes it, then return at
    // the next falling edge with start still high; idle_for lowers it.
    task automatic send_word(input logic signed [IN_W-1:0] x,
                             input logic signed [IN_W-1:0] y,
                             input logic signed [IN_W-1:0] z);
        start = 1'b1;
        accel_x_in = x;
        accel_y_in = y;
        accel_z_in = z;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drop start for a gap of length n; n of zero leaves it high for back-to-back words.
    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Hold off the sender until every word in flight has come back.
    task automatic drain_pipe();
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [IN_W-1:0] edge_value();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    // Build one random sample; the kinds aim at the interesting regions.
    task automatic make_sample(output logic signed [IN_W-1:0] x,
                               output logic signed [IN_W-1:0] y,
                               output logic signed [IN_W-1:0] z);
        int kind;
        int a;
        int b;
        int c;
        int s;
        kind = $urandom_range(0, 99);
        x = IN_W'($urandom);
        y = IN_W'($urandom);
        z = IN_W'($urandom);
        if (kind < 25)
        begin
            // full-range noise, already in place
        end
        else if (kind < 40)
        begin
            x = IN_W'($urandom_range(0, 16) - 8);
            y = IN_W'($urandom_range(0, 16) - 8);
            z = IN_W'($urandom_range(0, 16) - 8);
        end
        else if (kind < 50)
        begin
            case ($urandom_range(0, 2))
                0: x = '0;
                1: y = '0;
                default: z = '0;
            endcase
        end
        else if (kind < 58)
        begin
            // a single live axis: zero numerator or zero denominator
            case ($urandom_range(0, 2))
                0: begin y = '0; z = '0; end
                1: begin x = '0; z = '0; end
                default: begin x = '0; y = '0; end
            endcase
        end
        else if (kind < 75)
        begin
            // numerator close to the denominator magnitude: the 45 degree edge
            a = $urandom_range(0, 400) - 200;
            b = $urandom_range(0, 400) - 200;
            s = a * a + b * b;
            c = 0;
            while ((c + 1) * (c + 1) <= s)
                c++;
            c = c + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1) == 1)
                c = -c;
            if ($urandom_range(0, 1) == 1)
            begin
                x = IN_W'(a);
                z = IN_W'(b);
                y = IN_W'(c);
            end
            else
            begin
                y = IN_W'(a);
                z = IN_W'(b);
                x = IN_W'(c);
            end
        end
        else if (kind < 90)
        begin
            // gravity mostly along one axis, small tilt on the others
            a = $urandom_range(16000, 32767);
            if ($urandom_range(0, 1) == 1)
                a = -a;
            x = IN_W'($urandom_range(0, 1200) - 600);
            y = IN_W'($urandom_range(0, 1200) - 600);
            z = IN_W'($urandom_range(0, 1200) - 600);
            case ($urandom_range(0, 2))
                0: x = IN_W'(a);
                1: y = IN_W'(a);
                default: z = IN_W'(a);
            endcase
        end
        else
        begin
            x = edge_value();
            y = edge_value();
            z = edge_value();
        end
    endtask

    initial
    begin
        logic signed [IN_W-1:0] sx;
        logic signed [IN_W-1:0] sy;
        logic signed [IN_W-1:0] sz;
        bit                     calm;

        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        accel_x_in = '0;
        accel_y_in = '0;
        accel_z_in = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: extremes, the 45 degree boundary, vertical and flat.
        send_word(16'sd0, 16'sd0, 16'sd0);                    idle_for(gap_len());
        send_word(-16'sd32768, -16'sd32768, -16'sd32768);     idle_for(gap_len());
        send_word(16'sd32767, 16'sd32767, 16'sd32767);        idle_for(gap_len());
        send_word(16'sd32767, 16'sd0, 16'sd0);                idle_for(gap_len());
        send_word(-16'sd32768, 16'sd0, 16'sd0);               idle_for(gap_len());
        send_word(16'sd0, -16'sd32768, 16'sd0);               idle_for(gap_len());
        send_word(16'sd0, 16'sd32767, 16'sd0);                idle_for(gap_len());
        send_word(16'sd0, 16'sd0, -16'sd32768);               idle_for(gap_len());
        send_word(16'sd3, 16'sd5, 16'sd4);                    idle_for(gap_len());
        send_word(-16'sd3, -16'sd5, 16'sd4);                  idle_for(gap_len());
        send_word(16'sd1, 16'sd1, 16'sd0);                    idle_for(gap_len());
        send_word(-16'sd1, 16'sd1, 16'sd0);                   idle_for(gap_len());
        send_word(16'sd1, 16'sd4, 16'sd0);                    idle_for(gap_len());
        send_word(16'sd2, 16'sd3, 16'sd2);                    idle_for(gap_len());
        send_word(16'sd1, 16'sd32767, 16'sd0);                idle_for(gap_len());
        send_word(-16'sd32768, -16'sd1, 16'sd0);              idle_for(gap_len());
        send_word(16'sd32767, 16'sd1, 16'sd32767);            idle_for(gap_len());
        send_word(16'sd1, -16'sd1, -16'sd32768);              idle_for(gap_len());
        send_word(16'sd30000, 16'sd40, 16'sd0);               idle_for(gap_len());
        send_word(16'sd0, 16'sd0, 16'sd1);                    idle_for(gap_len());
        send_word(16'sd0, 16'sd7, -16'sd7);                   idle_for(gap_len());

        // Random words in ten blocks; two blocks run with no gaps at all,
        // and the sender drains the pipe after a few of them.
        for (int blk = 0; blk < 10; blk++)
        begin
            calm = (blk == 3 || blk == 7);
            for (int n = 0; n < 100; n++)
            begin
                make_sample(sx, sy, sz);
                send_word(sx, sy, sz);
                if (!calm)
                    idle_for(gap_len());
            end
            if (blk == 2 || blk == 5 || blk == 8)
                drain_pipe();
        end

        // Wait out every word still in flight, then a little more so a stray
        // done pulse would still be caught.
        drain_pipe();
        repeat (PIPE_DEPTH + 10) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("accel_tilt_pitch_roll verification clean");
        else
            $display("accel_tilt_pitch_roll verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("accel_tilt_pitch_roll verification failed");
        $finish;
    end

endmodule

FILE: accel_tilt_pitch_roll.f
src/atpr_pkg.sv
src/atpr_tilt.sv
src/accel_tilt_pitch_roll.sv
src/atpr_chk.sv
bench/testbench.sv
